// File: sv/grc_pkg.sv
// shared types and constants of the grid ray caster
`default_nettype none
package grc_pkg;

  localparam int SCREEN_COLUMNS = 64;
  localparam int SCREEN_ROWS    = 32;
  localparam int MAP_DIM        = 9;
  localparam int MAP_BITS       = 81;
  localparam int MAX_STEPS      = 2 * MAP_DIM + 2;
  localparam int CAM_SHIFT      = 8;          // 2^14 / SCREEN_COLUMNS as a shift
  localparam int DIV_W          = 26;
  localparam int ROW_HALF       = SCREEN_ROWS / 2;

  localparam logic [0:0] CFG_MAP_LOW  = 1'b0;
  localparam logic [0:0] CFG_MAP_HIGH = 1'b1;

  localparam logic [3:0] DIST_STEPS = 4'd8;
  localparam logic [3:0] H_STEPS    = 4'd5;

  typedef struct packed {
    logic load;
    logic init;
    logic mul;
    logic step;
    logic dist_start;
    logic h_start;
    logic div_run;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic dist_sat;
    logic h_sat;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/grc_div.sv
// restoring shift-subtract divider, one quotient bit per cycle while run is high
`default_nettype none
module grc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      run,
  input  wire logic [grc_pkg::DIV_W-1:0] dividend,
  input  wire logic [grc_pkg::DIV_W-1:0] divisor_sh,
  input  wire logic [3:0]                steps,
  output logic      [7:0]                quot,
  output logic                           last
);
  import grc_pkg::*;

  logic [DIV_W-1:0] rem_r, dsh_r;
  logic [7:0]       q_r;
  logic [3:0]       cnt_r;
  logic             ge;

  assign ge   = rem_r >= dsh_r;
  assign quot = q_r;
  assign last = cnt_r == 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (run) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= divisor_sh;
      q_r   <= 8'd0;
    end else if (run) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[6:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule
`default_nettype wire

// File: sv/grc_ctrl.sv
// sequencer for ray stepping, the two divisions and result hand-off
`default_nettype none
module grc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire grc_pkg::stat_t stat,
  output grc_pkg::cmd_t       cmd
);
  import grc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_DSET = 4'd4;
  localparam logic [3:0] S_DRUN = 4'd5;
  localparam logic [3:0] S_HSET = 4'd6;
  localparam logic [3:0] S_HRUN = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = stat.stop ? S_DSET : S_MUL;
      end
      S_DSET: begin
        cmd.dist_start = 1'b1;
        state_nxt      = stat.dist_sat ? S_HSET : S_DRUN;
      end
      S_DRUN: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_HSET;
        end
      end
      S_HSET: begin
        cmd.h_start = 1'b1;
        state_nxt   = stat.h_sat ? S_FIN : S_HRUN;
      end
      S_HRUN: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/grc_dpath.sv
// ray setup, grid stepping, wall lookup, division operands and result registers
`default_nettype none
module grc_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire grc_pkg::cmd_t      cmd,
  output grc_pkg::stat_t          stat,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic [5:0]         in_column,
  input  wire logic [15:0]        in_pos_x,
  input  wire logic [15:0]        in_pos_y,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_plane_x,
  input  wire logic signed [15:0] in_plane_y,
  output logic [7:0]              out_wall_dist8,
  output logic [4:0]              out_slice_start,
  output logic [5:0]              out_slice_end,
  output logic                    out_hit_side,
  output logic signed [4:0]       out_hit_cell_x,
  output logic signed [4:0]       out_hit_cell_y,
  output logic                    out_new_tile,
  output logic [31:0]             out_column_dark_mask,
  output logic [31:0]             out_prev_dark_mask
);
  import grc_pkg::*;

  // map registers
  logic [63:0] map_lo_r;
  logic [16:0] map_hi_r;
  logic [MAP_BITS-1:0] map_c;
  assign map_c = {map_hi_r, map_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_lo_r <= '0;
      map_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_LOW:  map_lo_r <= cfg_data;
        CFG_MAP_HIGH: map_hi_r <= cfg_data[16:0];
        default:      map_lo_r <= map_lo_r;
      endcase
    end
  end

  // input capture and camera products
  logic [5:0]         col_r;
  logic [15:0]        px_r, py_r;
  logic signed [15:0] dx_r, dy_r;
  logic signed [31:0] prx_r, pry_r;
  logic signed [8:0]  cam_c;
  logic signed [15:0] cam16;

  assign cam_c = $signed({2'b00, in_column, 1'b0}) - 9'sd64;
  assign cam16 = $signed({cam_c[7:0], {CAM_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_column;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      dx_r  <= in_dir_x;
      dy_r  <= in_dir_y;
      prx_r <= in_plane_x * cam16;
      pry_r <= in_plane_y * cam16;
    end
  end

  // ray direction and first boundary distances
  logic signed [17:0] rdx_c, rdy_c, nrdx_c, nrdy_c;
  assign rdx_c  = $signed({{2{dx_r[15]}}, dx_r}) + $signed(prx_r[31:14]);
  assign rdy_c  = $signed({{2{dy_r[15]}}, dy_r}) + $signed(pry_r[31:14]);
  assign nrdx_c = -rdx_c;
  assign nrdy_c = -rdy_c;

  logic               negx_r, negy_r, side_r;
  logic [16:0]        wx_r, wy_r, ax_r, ay_r, prevx_r, prevy_r;
  logic signed [6:0]  mx_r, my_r;
  logic [4:0]         stepcnt_r;
  logic [33:0]        pa_r, pb_r;
  logic [16:0]        cx_c, cy_c;
  logic               zero_ray;

  assign zero_ray = (wx_r == 17'd0) && (wy_r == 17'd0);
  assign cx_c     = zero_ray ? 17'd1 : wx_r;
  assign cy_c     = zero_ray ? 17'd1 : wy_r;

  // stepping
  logic              xstep;
  logic signed [6:0] nmx, nmy;
  logic              out_of_map, wall_c;
  logic [6:0]        idx_c;

  assign xstep = pa_r < pb_r;
  assign nmx   = xstep ? 7'(mx_r + (negx_r ? -7'sd1 : 7'sd1)) : mx_r;
  assign nmy   = xstep ? my_r : 7'(my_r + (negy_r ? -7'sd1 : 7'sd1));
  assign out_of_map = (nmx < 7'sd0) || (nmx >= 7'(MAP_DIM)) ||
                      (nmy < 7'sd0) || (nmy >= 7'(MAP_DIM));
  assign idx_c  = 7'(nmy[3:0] * 7'(MAP_DIM)) + {3'b000, nmx[3:0]};
  assign wall_c = out_of_map || ((idx_c < 7'(MAP_BITS)) && map_c[idx_c]);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      negx_r    <= rdx_c[17];
      negy_r    <= rdy_c[17];
      wx_r      <= rdx_c[17] ? nrdx_c[16:0] : rdx_c[16:0];
      wy_r      <= rdy_c[17] ? nrdy_c[16:0] : rdy_c[16:0];
      ax_r      <= rdx_c[17] ? {5'd0, px_r[11:0]} : 17'd4096 - {5'd0, px_r[11:0]};
      ay_r      <= rdy_c[17] ? {5'd0, py_r[11:0]} : 17'd4096 - {5'd0, py_r[11:0]};
      mx_r      <= {3'b000, px_r[15:12]};
      my_r      <= {3'b000, py_r[15:12]};
      prevx_r   <= 17'd0;
      prevy_r   <= 17'd0;
      side_r    <= 1'b0;
      stepcnt_r <= 5'd0;
    end else if (cmd.step) begin
      if (xstep) begin
        prevx_r <= ax_r;
        ax_r    <= ax_r + 17'd4096;
      end else begin
        prevy_r <= ay_r;
        ay_r    <= ay_r + 17'd4096;
      end
      mx_r      <= nmx;
      my_r      <= nmy;
      side_r    <= !xstep;
      stepcnt_r <= stepcnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_r <= ax_r * cy_c;
      pb_r <= ay_r * cx_c;
    end
  end

  // division operands
  logic [16:0]      num_c, w_c;
  logic             zero_w;
  logic [24:0]      num200_c;
  logic [DIV_W-1:0] dividend_c, divisor_c;
  logic [7:0]       quot;
  logic [7:0]       dist_q_r;
  logic             div_last;

  assign num_c    = side_r ? prevy_r : prevx_r;
  assign w_c      = side_r ? wy_r : wx_r;
  assign zero_w   = w_c == 17'd0;
  assign num200_c = 25'(num_c * 25'd200);

  always_comb begin
    if (cmd.dist_start) begin
      dividend_c = {1'b0, num200_c};
      divisor_c  = {2'b00, w_c, 7'd0};
    end else begin
      dividend_c = {6'd0, w_c, 3'd0};
      divisor_c  = {5'd0, num_c, 4'd0};
    end
  end

  grc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.dist_start || cmd.h_start),
    .run        (cmd.div_run),
    .dividend   (dividend_c),
    .divisor_sh (divisor_c),
    .steps      (cmd.dist_start ? DIST_STEPS : H_STEPS),
    .quot       (quot),
    .last       (div_last)
  );

  always_ff @(posedge clk) begin
    if (cmd.h_start) begin
      dist_q_r <= quot;
    end
  end

  assign stat.stop     = wall_c || (stepcnt_r == 5'(MAX_STEPS - 1));
  assign stat.dist_sat = zero_w || (num200_c >= {w_c, 8'd0});
  assign stat.h_sat    = zero_w || ({2'b00, w_c} >= {num_c, 2'b00});
  assign stat.div_last = div_last;

  // result assembly
  logic [5:0]  h_c;
  logic [4:0]  half_c, start_c;
  logic [5:0]  end_c, endm1_c;
  logic [31:0] rng_c, chk_c, cmask_c;
  logic [4:0]  hx_c, hy_c;
  logic [4:0]  last_x_r, last_y_r;
  logic        newt_c;

  assign h_c     = zero_w ? 6'd0 : (stat.h_sat ? 6'(SCREEN_ROWS) : {1'b0, quot[4:0]});
  assign half_c  = h_c[5:1];
  assign start_c = 5'(ROW_HALF) - half_c;
  assign end_c   = 6'(ROW_HALF) + {1'b0, half_c};
  assign endm1_c = end_c - 6'd1;
  assign chk_c   = col_r[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
  assign hx_c    = mx_r[4:0];
  assign hy_c    = my_r[4:0];
  assign newt_c  = (hx_c != last_x_r) || (hy_c != last_y_r);

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rng_c[i] = (6'(i) >= {1'b0, start_c}) && (6'(i) < end_c);
    end
    cmask_c = rng_c & chk_c;
    cmask_c[start_c] = 1'b1;
    if (endm1_c < 6'd32) begin
      cmask_c[endm1_c[4:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= 5'h1F;
      last_y_r <= 5'h1F;
    end else if (cmd.fin) begin
      last_x_r <= hx_c;
      last_y_r <= hy_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_wall_dist8       <= stat.dist_sat ? 8'd255 : dist_q_r;
      out_slice_start      <= start_c;
      out_slice_end        <= end_c;
      out_hit_side         <= side_r;
      out_hit_cell_x       <= $signed(hx_c);
      out_hit_cell_y       <= $signed(hy_c);
      out_new_tile         <= newt_c;
      out_column_dark_mask <= cmask_c;
      out_prev_dark_mask   <= (newt_c && (col_r != 6'd0)) ? rng_c : 32'd0;
    end
  end

endmodule
`default_nettype wire

// File: sv/grid_raycast_column_top.sv
// top level of the column ray caster: sequencer plus datapath
// sequence: the step loop takes up to 20 grid steps, each through the multiply and step states,
//   then the shared bit-serial divider gives up to 8 distance and up to 5 height quotient bits
// one column in work at a time; a finished result waits in the output register while the next
//   column is accepted and stepped
// reset: synchronous active-low rst_n clears the map, the sequencer, out_valid and sets the
//   previous hit cell to minus one
`default_nettype none
module grid_raycast_column_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [5:0]         in_column,
  input  wire logic [15:0]        in_pos_x,
  input  wire logic [15:0]        in_pos_y,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_plane_x,
  input  wire logic signed [15:0] in_plane_y,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_wall_dist8,
  output logic [4:0]              out_slice_start,
  output logic [5:0]              out_slice_end,
  output logic                    out_hit_side,
  output logic signed [4:0]       out_hit_cell_x,
  output logic signed [4:0]       out_hit_cell_y,
  output logic                    out_new_tile,
  output logic [31:0]             out_column_dark_mask,
  output logic [31:0]             out_prev_dark_mask
);
  import grc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // map writes are always taken, one transaction per cycle
  assign cfg_ready = 1'b1;

  // sequencer: accept, step loop, divisions, hand-off to output register
  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: camera ray, dda stepping, wall lookup, divider, masks
  grc_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_column            (in_column),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_dir_x             (in_dir_x),
    .in_dir_y             (in_dir_y),
    .in_plane_x           (in_plane_x),
    .in_plane_y           (in_plane_y),
    .out_wall_dist8       (out_wall_dist8),
    .out_slice_start      (out_slice_start),
    .out_slice_end        (out_slice_end),
    .out_hit_side         (out_hit_side),
    .out_hit_cell_x       (out_hit_cell_x),
    .out_hit_cell_y       (out_hit_cell_y),
    .out_new_tile         (out_new_tile),
    .out_column_dark_mask (out_column_dark_mask),
    .out_prev_dark_mask   (out_prev_dark_mask)
  );

endmodule
`default_nettype wire

// File: sv/grc_checker.sv
// port-level checks of the column ray caster and their bind
`default_nettype none
module grc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_wall_dist8,
  input wire logic [4:0]  out_slice_start,
  input wire logic [5:0]  out_slice_end,
  input wire logic        out_new_tile,
  input wire logic [31:0] out_column_dark_mask,
  input wire logic [31:0] out_prev_dark_mask
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wall_dist8))
    else $error("result changed while stalled");

  // slice is centered on the middle row
  a_slice_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_slice_start} + out_slice_end) == 7'd32)
    else $error("slice not centered");

  // top edge row always darkened
  a_edge_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_column_dark_mask >> out_slice_start) & 32'd1) != 32'd0)
    else $error("slice start row not darkened");

  // previous column mask only on a new tile
  a_prev_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_prev_dark_mask != 32'd0) |-> out_new_tile)
    else $error("previous mask without new tile");

  // one column in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

bind grid_raycast_column_top grc_checker u_grc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_wall_dist8       (out_wall_dist8),
  .out_slice_start      (out_slice_start),
  .out_slice_end        (out_slice_end),
  .out_new_tile         (out_new_tile),
  .out_column_dark_mask (out_column_dark_mask),
  .out_prev_dark_mask   (out_prev_dark_mask)
);
`default_nettype wire
